/* rtl/afk_pkg.sv */
package afk_pkg;

  localparam int ANGLE_FRAC_BITS = 13;
  localparam int WORK_BITS       = 30;
  localparam int ANG_SHIFT       = WORK_BITS - ANGLE_FRAC_BITS;

  // Angle word: Q6.30 with room for two turns of wrap on the elbow sum.
  localparam int ZW = 36;
  // CORDIC vector word.
  localparam int XW = 34;

  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LINK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORE_LINK   = 2'd2;

  localparam logic signed [ZW-1:0] HALF_PI  = 36'sd1686629713;
  localparam logic signed [ZW-1:0] PI       = 36'sd3373259426;
  localparam logic signed [ZW-1:0] TWO_PI   = 36'sd6746518852;
  localparam logic signed [ZW-1:0] THREE_PI = 36'sd10119778278;
  localparam logic signed [ZW-1:0] FOUR_PI  = 36'sd13493037704;
  localparam logic signed [XW-1:0] GAIN     = 34'sd652032874;

  localparam int XY_MAX = 65534;
  localparam int Z_MAX  = 98301;

  localparam int TABLE_LEN = 24;

  typedef struct packed {
    logic [CFG_W-1:0] base_height;
    logic [CFG_W-1:0] upper_link;
    logic [CFG_W-1:0] fore_link;
  } afk_cfg_t;

  function automatic logic signed [ZW-1:0] atan_f(input int i);
    logic signed [ZW-1:0] v;
    unique case (i)
      0:  v = 36'sd843314856;
      1:  v = 36'sd497837829;
      2:  v = 36'sd263043836;
      3:  v = 36'sd133525158;
      4:  v = 36'sd67021686;
      5:  v = 36'sd33543515;
      6:  v = 36'sd16775850;
      7:  v = 36'sd8388437;
      8:  v = 36'sd4194282;
      9:  v = 36'sd2097149;
      10: v = 36'sd1048575;
      11: v = 36'sd524287;
      12: v = 36'sd262143;
      13: v = 36'sd131071;
      14: v = 36'sd65535;
      15: v = 36'sd32767;
      16: v = 36'sd16383;
      17: v = 36'sd8191;
      18: v = 36'sd4095;
      19: v = 36'sd2047;
      20: v = 36'sd1023;
      21: v = 36'sd511;
      22: v = 36'sd255;
      23: v = 36'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/afk_cordic.sv */
module afk_cordic
  import afk_pkg::*;
#(
  parameter int Steps = 16
) (
  input  logic                 clk_i,
  input  logic signed [ZW-1:0] angle_i,
  output logic signed [XW-1:0] cos_o,
  output logic signed [XW-1:0] sin_o
);

  logic signed [ZW-1:0] wrap_q;
  logic signed [XW-1:0] x_q [Steps+1];
  logic signed [XW-1:0] y_q [Steps+1];
  logic signed [ZW-1:0] z_q [Steps+1];
  logic                 neg_q [Steps+1];

  // Wrap into (-pi, pi].
  always_ff @(posedge clk_i) begin
    if (angle_i > THREE_PI) begin
      wrap_q <= angle_i - FOUR_PI;
    end else if (angle_i > PI) begin
      wrap_q <= angle_i - TWO_PI;
    end else if (angle_i <= -THREE_PI) begin
      wrap_q <= angle_i + FOUR_PI;
    end else if (angle_i <= -PI) begin
      wrap_q <= angle_i + TWO_PI;
    end else begin
      wrap_q <= angle_i;
    end
  end

  // Fold into [-pi/2, pi/2], remember the sign flip.
  always_ff @(posedge clk_i) begin
    x_q[0] <= GAIN;
    y_q[0] <= '0;
    if (wrap_q > HALF_PI) begin
      z_q[0]   <= wrap_q - PI;
      neg_q[0] <= 1'b1;
    end else if (wrap_q < -HALF_PI) begin
      z_q[0]   <= wrap_q + PI;
      neg_q[0] <= 1'b1;
    end else begin
      z_q[0]   <= wrap_q;
      neg_q[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      neg_q[i+1] <= neg_q[i];
      if (z_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - atan_f(i);
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + atan_f(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cos_o <= neg_q[Steps] ? -x_q[Steps] : x_q[Steps];
    sin_o <= neg_q[Steps] ? -y_q[Steps] : y_q[Steps];
  end

endmodule

/* rtl/afk_combine.sv */
module afk_combine
  import afk_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  afk_cfg_t             cfg_i,
  input  logic signed [XW-1:0] c1_i,
  input  logic signed [XW-1:0] s1_i,
  input  logic signed [XW-1:0] c2_i,
  input  logic signed [XW-1:0] s2_i,
  input  logic signed [XW-1:0] c23_i,
  input  logic signed [XW-1:0] s23_i,
  output logic                 valid_o,
  output logic signed [16:0]   tool_x_o,
  output logic signed [16:0]   tool_y_o,
  output logic signed [17:0]   tool_z_o
);

  localparam int PW = XW + CFG_W + 1;   // link times cosine
  localparam int SW = PW + 1;           // sum of two products
  localparam int RW = SW - 15;          // reach in Q15
  localparam int MW = RW + XW;          // reach times cos q1
  localparam int OW = MW - 45;          // rounded x / y
  localparam int ZHW = SW - 30 + 2;     // rounded height plus base

  logic [3:0] vld_q;

  logic signed [PW-1:0] p2c_q, p3c_q, p2s_q, p3s_q;
  logic signed [XW-1:0] c1_1_q, s1_1_q, c1_2_q, s1_2_q, c1_3_q, s1_3_q;
  logic signed [SW-1:0] r_q, h_q;
  logic signed [RW-1:0] r15_q;
  logic signed [ZHW-1:0] zs_q, zs4_q;
  logic signed [MW-1:0] px_q, py_q;

  logic signed [SW-1:0] r_rnd, h_rnd;
  logic signed [MW-1:0] px_rnd, py_rnd;
  logic signed [OW-1:0] xr, yr;
  logic signed [ZHW-1:0] h_int;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else begin
      vld_q   <= {vld_q[2:0], valid_i};
      valid_o <= vld_q[3];
    end
  end

  // Products with the link lengths.
  always_ff @(posedge clk_i) begin
    p2c_q  <= PW'(c2_i * $signed({1'b0, cfg_i.upper_link}));
    p3c_q  <= PW'(c23_i * $signed({1'b0, cfg_i.fore_link}));
    p2s_q  <= PW'(s2_i * $signed({1'b0, cfg_i.upper_link}));
    p3s_q  <= PW'(s23_i * $signed({1'b0, cfg_i.fore_link}));
    c1_1_q <= c1_i;
    s1_1_q <= s1_i;
  end

  // Reach and height in Q30.
  always_ff @(posedge clk_i) begin
    r_q    <= SW'(p2c_q) + SW'(p3c_q);
    h_q    <= SW'(p2s_q) + SW'(p3s_q);
    c1_2_q <= c1_1_q;
    s1_2_q <= s1_1_q;
  end

  assign r_rnd = r_q + (SW'(1) <<< 14);
  assign h_rnd = h_q + (SW'(1) <<< 29);
  assign h_int = ZHW'(h_rnd >>> 30);

  always_ff @(posedge clk_i) begin
    r15_q  <= RW'(r_rnd >>> 15);
    zs_q   <= h_int + $signed(ZHW'({1'b0, cfg_i.base_height}));
    c1_3_q <= c1_2_q;
    s1_3_q <= s1_2_q;
  end

  always_ff @(posedge clk_i) begin
    px_q  <= MW'(r15_q * c1_3_q);
    py_q  <= MW'(r15_q * s1_3_q);
    zs4_q <= zs_q;
  end

  assign px_rnd = px_q + (MW'(1) <<< 44);
  assign py_rnd = py_q + (MW'(1) <<< 44);
  assign xr     = OW'(px_rnd >>> 45);
  assign yr     = OW'(py_rnd >>> 45);

  // Saturate to the output ranges.
  always_ff @(posedge clk_i) begin
    if (xr > OW'(XY_MAX)) begin
      tool_x_o <= 17'(XY_MAX);
    end else if (xr < -OW'(XY_MAX)) begin
      tool_x_o <= -17'(XY_MAX);
    end else begin
      tool_x_o <= 17'(xr);
    end
    if (yr > OW'(XY_MAX)) begin
      tool_y_o <= 17'(XY_MAX);
    end else if (yr < -OW'(XY_MAX)) begin
      tool_y_o <= -17'(XY_MAX);
    end else begin
      tool_y_o <= 17'(yr);
    end
    if (zs4_q > ZHW'(Z_MAX)) begin
      tool_z_o <= 18'(Z_MAX);
    end else if (zs4_q < -ZHW'(XY_MAX)) begin
      tool_z_o <= -18'(XY_MAX);
    end else begin
      tool_z_o <= 18'(zs4_q);
    end
  end

endmodule

/* rtl/arm_forward_kinematics_3dof_unit.sv */
// Throughput: one item per cycle; busy stays low, results leave on a one-cycle strobe.
// The depth is set by the unrolled CORDIC, one shift-add rotation per stage, plus
// the multiply, sum, round, second multiply and saturate stages behind it. The receiver
// cannot stall. Reset zeroes the link registers and drops every item in flight.
module arm_forward_kinematics_3dof_unit
  import afk_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [15:0]   base_angle_i,
  input  logic signed [15:0]   shoulder_angle_i,
  input  logic signed [15:0]   elbow_angle_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 done,
  output logic signed [16:0]   tool_x_o,
  output logic signed [16:0]   tool_y_o,
  output logic signed [17:0]   tool_z_o
);

  // Input stage + wrap + fold + steps + sign fix.
  localparam int CordicLat = CORDIC_STEPS + 4;

  afk_cfg_t cfg_q;
  logic [CordicLat-1:0] vld_q;

  logic signed [ZW-1:0] q1_d, q2_d, q3_d;
  logic signed [ZW-1:0] q1_q, q2_q, q3_q;
  logic signed [ZW-1:0] sh_w, el_w;

  logic signed [XW-1:0] c1, s1, c2, s2, c23, s23;

  // Never stall: the pipeline advances every cycle.
  assign busy = 1'b0;

  // Link registers; an index past the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BASE_HEIGHT: cfg_q.base_height <= cfg_data_i;
        REG_UPPER_LINK:  cfg_q.upper_link  <= cfg_data_i;
        REG_FORE_LINK:   cfg_q.fore_link   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Carry the valid bit alongside the CORDIC data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[CordicLat-2:0], start & ~busy};
    end
  end

  // Scale the joint angles to Q6.30 and form q1, q2 = pi - sh and q3 = pi/2 - sh - el.
  assign sh_w = ZW'(shoulder_angle_i) <<< ANG_SHIFT;
  assign el_w = ZW'(elbow_angle_i) <<< ANG_SHIFT;
  assign q1_d = ZW'(base_angle_i) <<< ANG_SHIFT;
  assign q2_d = PI - sh_w;
  assign q3_d = HALF_PI - sh_w - el_w;

  always_ff @(posedge clk_i) begin
    q1_q <= q1_d;
    q2_q <= q2_d;
    q3_q <= q3_d;
  end

  afk_cordic #(.Steps(CORDIC_STEPS)) u_cordic_base (
    .clk_i   (clk_i),
    .angle_i (q1_q),
    .cos_o   (c1),
    .sin_o   (s1)
  );

  afk_cordic #(.Steps(CORDIC_STEPS)) u_cordic_shoulder (
    .clk_i   (clk_i),
    .angle_i (q2_q),
    .cos_o   (c2),
    .sin_o   (s2)
  );

  afk_cordic #(.Steps(CORDIC_STEPS)) u_cordic_elbow (
    .clk_i   (clk_i),
    .angle_i (q3_q),
    .cos_o   (c23),
    .sin_o   (s23)
  );

  afk_combine u_combine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vld_q[CordicLat-1]),
    .cfg_i    (cfg_q),
    .c1_i     (c1),
    .s1_i     (s1),
    .c2_i     (c2),
    .s2_i     (s2),
    .c23_i    (c23),
    .s23_i    (s23),
    .valid_o  (done),
    .tool_x_o (tool_x_o),
    .tool_y_o (tool_y_o),
    .tool_z_o (tool_z_o)
  );

endmodule

/* rtl/afk_checker.sv */
module afk_checker #(
  parameter int Latency = 25
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [16:0] tool_x_o,
  input logic signed [16:0] tool_y_o,
  input logic signed [17:0] tool_z_o
);

  a_accept_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency done) else $error("missing result");

  a_done_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> $past(start && !busy, Latency)) else $error("spurious result");

  a_xy_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (tool_x_o <= 17'sd65534 && tool_x_o >= -17'sd65534 &&
              tool_y_o <= 17'sd65534 && tool_y_o >= -17'sd65534))
    else $error("x/y out of range");

  a_z_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (tool_z_o <= 18'sd98301 && tool_z_o >= -18'sd65534))
    else $error("z out of range");

endmodule

bind arm_forward_kinematics_3dof_unit afk_checker #(.Latency(CORDIC_STEPS + 9)) u_afk_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .tool_x_o (tool_x_o),
  .tool_y_o (tool_y_o),
  .tool_z_o (tool_z_o)
);
